@@ rtl/bfg_pkg.sv @@
// ----------------------------------------------------------------------------
// bfg_pkg
// shared types, constants and helpers of the 5x7 glyph rasterizer
// ----------------------------------------------------------------------------
package bfg_pkg;

	localparam int CHAR_FIRST   = 32;
	localparam int CHAR_LAST    = 126;
	localparam int GLYPH_COUNT  = 95;
	localparam int GLYPH_ROWS   = 7;
	localparam int GLYPH_COLS   = 5;
	localparam int GLYPH_BITS   = GLYPH_ROWS * GLYPH_COLS;
	localparam int PIX_IDX_W    = 6;
	localparam int CELL_ADVANCE = 6;
	localparam int SUM_W        = 35;

	localparam logic [1:0] CFG_ORIGIN_X    = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y    = 2'd1;
	localparam logic [1:0] CFG_PIXEL_SCALE = 2'd2;
	localparam logic [1:0] CFG_TEXT_COLOR  = 2'd3;

	typedef struct packed {
		logic [GLYPH_BITS-1:0] glyph;
		logic signed [15:0]    base_y;
		logic [7:0]            scale;
		logic [31:0]           color;
		logic                  shadow;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	localparam logic [4:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
		'{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00},
		'{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h00,5'h00},
		'{5'h0E,5'h15,5'h0E,5'h15,5'h0E,5'h00,5'h00}, '{5'h19,5'h1A,5'h04,5'h0B,5'h13,5'h00,5'h00},
		'{5'h0C,5'h12,5'h0C,5'h15,5'h0A,5'h00,5'h00}, '{5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
		'{5'h02,5'h04,5'h04,5'h04,5'h02,5'h00,5'h00}, '{5'h08,5'h04,5'h04,5'h04,5'h08,5'h00,5'h00},
		'{5'h00,5'h15,5'h0E,5'h15,5'h00,5'h00,5'h00}, '{5'h00,5'h04,5'h0E,5'h04,5'h00,5'h00,5'h00},
		'{5'h00,5'h00,5'h00,5'h04,5'h08,5'h00,5'h00}, '{5'h00,5'h00,5'h0E,5'h00,5'h00,5'h00,5'h00},
		'{5'h00,5'h00,5'h00,5'h00,5'h04,5'h00,5'h00}, '{5'h01,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00},
		'{5'h0E,5'h13,5'h15,5'h19,5'h0E,5'h00,5'h00}, '{5'h04,5'h0C,5'h04,5'h04,5'h0E,5'h00,5'h00},
		'{5'h0E,5'h11,5'h06,5'h08,5'h1F,5'h00,5'h00}, '{5'h0E,5'h11,5'h06,5'h11,5'h0E,5'h00,5'h00},
		'{5'h02,5'h06,5'h0A,5'h1F,5'h02,5'h00,5'h00}, '{5'h1F,5'h10,5'h1E,5'h01,5'h1E,5'h00,5'h00},
		'{5'h06,5'h08,5'h1E,5'h11,5'h0E,5'h00,5'h00}, '{5'h1F,5'h01,5'h02,5'h04,5'h04,5'h00,5'h00},
		'{5'h0E,5'h11,5'h0E,5'h11,5'h0E,5'h00,5'h00}, '{5'h0E,5'h11,5'h0F,5'h01,5'h0E,5'h00,5'h00},
		'{5'h00,5'h04,5'h00,5'h04,5'h00,5'h00,5'h00}, '{5'h00,5'h04,5'h00,5'h04,5'h08,5'h00,5'h00},
		'{5'h02,5'h04,5'h08,5'h04,5'h02,5'h00,5'h00}, '{5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00},
		'{5'h08,5'h04,5'h02,5'h04,5'h08,5'h00,5'h00}, '{5'h0E,5'h11,5'h06,5'h00,5'h04,5'h00,5'h00},
		'{5'h0E,5'h11,5'h17,5'h16,5'h0F,5'h00,5'h00}, '{5'h04,5'h0A,5'h11,5'h1F,5'h11,5'h00,5'h00},
		'{5'h1E,5'h11,5'h1E,5'h11,5'h1E,5'h00,5'h00}, '{5'h0E,5'h11,5'h10,5'h11,5'h0E,5'h00,5'h00},
		'{5'h1C,5'h12,5'h11,5'h12,5'h1C,5'h00,5'h00}, '{5'h1F,5'h10,5'h1E,5'h10,5'h1F,5'h00,5'h00},
		'{5'h1F,5'h10,5'h1E,5'h10,5'h10,5'h00,5'h00}, '{5'h0E,5'h10,5'h17,5'h11,5'h0E,5'h00,5'h00},
		'{5'h11,5'h11,5'h1F,5'h11,5'h11,5'h00,5'h00}, '{5'h0E,5'h04,5'h04,5'h04,5'h0E,5'h00,5'h00},
		'{5'h01,5'h01,5'h01,5'h11,5'h0E,5'h00,5'h00}, '{5'h11,5'h12,5'h1C,5'h12,5'h11,5'h00,5'h00},
		'{5'h10,5'h10,5'h10,5'h10,5'h1F,5'h00,5'h00}, '{5'h11,5'h1B,5'h15,5'h11,5'h11,5'h00,5'h00},
		'{5'h11,5'h19,5'h15,5'h13,5'h11,5'h00,5'h00}, '{5'h0E,5'h11,5'h11,5'h11,5'h0E,5'h00,5'h00},
		'{5'h1E,5'h11,5'h1E,5'h10,5'h10,5'h00,5'h00}, '{5'h0E,5'h11,5'h11,5'h13,5'h0D,5'h00,5'h00},
		'{5'h1E,5'h11,5'h1E,5'h12,5'h11,5'h00,5'h00}, '{5'h0F,5'h10,5'h0E,5'h01,5'h1E,5'h00,5'h00},
		'{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h00,5'h00}, '{5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00,5'h00},
		'{5'h11,5'h11,5'h11,5'h0A,5'h04,5'h00,5'h00}, '{5'h11,5'h11,5'h15,5'h1B,5'h11,5'h00,5'h00},
		'{5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h00,5'h00}, '{5'h11,5'h0A,5'h04,5'h04,5'h04,5'h00,5'h00},
		'{5'h1F,5'h02,5'h04,5'h08,5'h1F,5'h00,5'h00}, '{5'h0E,5'h08,5'h08,5'h08,5'h0E,5'h00,5'h00},
		'{5'h10,5'h08,5'h04,5'h02,5'h01,5'h00,5'h00}, '{5'h0E,5'h02,5'h02,5'h02,5'h0E,5'h00,5'h00},
		'{5'h04,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00},
		'{5'h08,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h00,5'h0E,5'h01,5'h0F,5'h0F,5'h00,5'h00},
		'{5'h10,5'h1E,5'h11,5'h11,5'h1E,5'h00,5'h00}, '{5'h00,5'h0E,5'h10,5'h10,5'h0E,5'h00,5'h00},
		'{5'h01,5'h0F,5'h11,5'h11,5'h0F,5'h00,5'h00}, '{5'h00,5'h0E,5'h11,5'h1F,5'h0E,5'h00,5'h00},
		'{5'h06,5'h04,5'h0E,5'h04,5'h04,5'h00,5'h00}, '{5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E,5'h00},
		'{5'h10,5'h1E,5'h11,5'h11,5'h11,5'h00,5'h00}, '{5'h04,5'h00,5'h04,5'h04,5'h04,5'h00,5'h00},
		'{5'h02,5'h00,5'h02,5'h02,5'h12,5'h0C,5'h00}, '{5'h10,5'h11,5'h16,5'h1C,5'h12,5'h00,5'h00},
		'{5'h0C,5'h04,5'h04,5'h04,5'h0E,5'h00,5'h00}, '{5'h00,5'h1A,5'h15,5'h15,5'h11,5'h00,5'h00},
		'{5'h00,5'h1E,5'h11,5'h11,5'h11,5'h00,5'h00}, '{5'h00,5'h0E,5'h11,5'h11,5'h0E,5'h00,5'h00},
		'{5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10,5'h00}, '{5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01,5'h00},
		'{5'h00,5'h16,5'h19,5'h10,5'h10,5'h00,5'h00}, '{5'h00,5'h0E,5'h10,5'h0E,5'h01,5'h0E,5'h00},
		'{5'h04,5'h0E,5'h04,5'h04,5'h06,5'h00,5'h00}, '{5'h00,5'h11,5'h11,5'h11,5'h0F,5'h00,5'h00},
		'{5'h00,5'h11,5'h11,5'h0A,5'h04,5'h00,5'h00}, '{5'h00,5'h11,5'h15,5'h15,5'h0A,5'h00,5'h00},
		'{5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h00}, '{5'h00,5'h11,5'h0A,5'h04,5'h08,5'h10,5'h00},
		'{5'h00,5'h1F,5'h02,5'h04,5'h1F,5'h00,5'h00}, '{5'h06,5'h04,5'h08,5'h04,5'h06,5'h00,5'h00},
		'{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h00}, '{5'h0C,5'h04,5'h02,5'h04,5'h0C,5'h00,5'h00},
		'{5'h08,5'h15,5'h02,5'h00,5'h00,5'h00,5'h00}
	};

	// clamp to the signed range of a cw-bit coordinate
	function automatic logic signed [SUM_W-1:0] sat_coord(logic signed [SUM_W-1:0] v, int cw);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = (SUM_W'(1) <<< (cw - 1)) - SUM_W'(1);
		lo = ~hi;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

@@ rtl/bfg_if.sv @@
// ----------------------------------------------------------------------------
// bfg channels
// valid/ready channels for characters in and squares out
// ----------------------------------------------------------------------------
interface bfg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       mode;
	logic       first_of_string;

	modport source(output valid, char_code, mode, first_of_string, input ready);
	modport sink(input valid, char_code, mode, first_of_string, output ready);
endinterface

interface bfg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [7:0]         rect_size;
	logic [31:0]        rect_color;
	logic               last_of_glyph;

	modport source(output valid, rect_x, rect_y, rect_size, rect_color, last_of_glyph,
		input ready);
	modport sink(input valid, rect_x, rect_y, rect_size, rect_color, last_of_glyph,
		output ready);
endinterface

@@ rtl/bitmap_font_glyph_rasterizer_core.sv @@
// a taken character is queued, loaded into the pixel walker, then its squares are registered out
// throughput: one square per cycle unless the output stalls or the walker loads a new glyph
// the pixel walker sets the rate; blank codes are taken without entering the queue
// a two-entry command queue lets the front take characters while squares drain
// reset clears cursor and queue, config returns to origin 0, scale 1, color all ones
// ----------------------------------------------------------------------------
// bitmap_font_glyph_rasterizer_core
// 5x7 character generator emitting one filled square per lit font pixel
// ----------------------------------------------------------------------------
module bitmap_font_glyph_rasterizer_core
	import bfg_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bfg_in_if.sink      glyph_in,
	bfg_out_if.source   rect_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int QW = COORD_WIDTH + CMD_W;

	logic          push;
	logic [QW-1:0] push_data;
	logic          pop;
	logic [QW-1:0] pop_data;
	logic          full;
	logic          empty;
	logic          back_busy;
	cmd_t          push_cmd;

	assign push_cmd = push_data[CMD_W-1:0];

	bfg_front #(.CW(COORD_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.glyph_in  (glyph_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	bfg_fifo #(.DATA_W(QW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	bfg_back #(.CW(COORD_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.busy     (back_busy),
		.rect_out (rect_out)
	);

`ifndef SYNTHESIS
	a_no_blank_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_cmd.glyph != '0))
		else $error("blank glyph queued");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rect_out.valid |-> (rect_out.rect_size != 8'd0))
		else $error("square of size zero");

	a_pop_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> back_busy)
		else $error("pixel walker idle after load");
`endif

endmodule

@@ rtl/bfg_front.sv @@
// ----------------------------------------------------------------------------
// bfg_front
// takes characters, holds config and cursor, queues lit glyphs
// ----------------------------------------------------------------------------
module bfg_front
	import bfg_pkg::*;
#(
	parameter int CW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	bfg_in_if.sink            glyph_in,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              full,
	output logic              push,
	output logic [CW+CMD_W-1:0] push_data
);

	logic [15:0] origin_x_q;
	logic [15:0] origin_y_q;
	logic [7:0]  pixel_scale_q;
	logic [31:0] text_color_q;
	logic signed [CW-1:0] cursor_q;

	logic                    accept;
	logic                    printable;
	logic [7:0]              code_off;
	logic [6:0]              rom_idx;
	logic [GLYPH_BITS-1:0]   glyph;
	logic [7:0]              scale;
	logic                    shadow;
	logic [9:0]              alpha3;
	logic signed [SUM_W-1:0] cur_base;
	logic signed [SUM_W-1:0] cur_next;
	logic [10:0]             advance;
	cmd_t                    cmd;

	assign glyph_in.ready = !full;
	assign accept = glyph_in.valid && !full;

	assign printable = (glyph_in.char_code >= 8'(CHAR_FIRST)) &&
		(glyph_in.char_code <= 8'(CHAR_LAST));
	assign code_off = glyph_in.char_code - 8'(CHAR_FIRST);
	assign rom_idx = printable ? code_off[6:0] : 7'd0;

	always_comb begin
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			for (int c = 0; c < GLYPH_COLS; c++) begin
				glyph[r*GLYPH_COLS + c] = printable &&
					FONT_ROM[rom_idx][r][GLYPH_COLS-1-c];
			end
		end
	end

	assign scale = (pixel_scale_q == 8'd0) ? 8'd1 : pixel_scale_q;
	assign shadow = !glyph_in.mode;
	assign alpha3 = 10'(text_color_q[7:0]) * 10'd3;

	assign cur_base = glyph_in.first_of_string ?
		sat_coord(SUM_W'(signed'(origin_x_q)), CW) : SUM_W'(cursor_q);
	assign advance = 11'(scale) * 11'(CELL_ADVANCE);
	assign cur_next = sat_coord(cur_base + SUM_W'(advance), CW);

	always_comb begin
		cmd.glyph  = glyph;
		cmd.base_y = signed'(origin_y_q);
		cmd.scale  = scale;
		cmd.color  = shadow ? {24'd0, alpha3[9:2]} : text_color_q;
		cmd.shadow = shadow;
	end

	assign push = accept && (glyph != '0);
	assign push_data = {cur_base[CW-1:0], cmd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			pixel_scale_q <= 8'd1;
			text_color_q  <= 32'hFFFF_FFFF;
			cursor_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIGIN_X:    origin_x_q    <= cfg_data[15:0];
					CFG_ORIGIN_Y:    origin_y_q    <= cfg_data[15:0];
					CFG_PIXEL_SCALE: pixel_scale_q <= cfg_data[7:0];
					CFG_TEXT_COLOR:  text_color_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				cursor_q <= cur_next[CW-1:0];
			end
		end
	end

endmodule

@@ rtl/bfg_fifo.sv @@
// ----------------------------------------------------------------------------
// bfg_fifo
// two-entry queue of glyph commands between front and back
// ----------------------------------------------------------------------------
module bfg_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              full,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/bfg_back.sv @@
// ----------------------------------------------------------------------------
// bfg_back
// walks the lit pixels of one glyph, one square per cycle unless the output stalls
// ----------------------------------------------------------------------------
module bfg_back
	import bfg_pkg::*;
#(
	parameter int CW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  logic [CW+CMD_W-1:0] pop_data,
	output logic                pop,
	output logic                busy,
	bfg_out_if.source           rect_out
);

	logic                  busy_q;
	logic [GLYPH_BITS-1:0] mask_q;
	logic signed [CW-1:0]  cursor_q;
	logic signed [15:0]    base_y_q;
	logic [7:0]            scale_q;
	logic [31:0]           color_q;
	logic                  shadow_q;

	logic                  out_valid_q;
	logic signed [15:0]    rect_x_q;
	logic signed [15:0]    rect_y_q;
	logic [7:0]            rect_size_q;
	logic [31:0]           rect_color_q;
	logic                  last_q;

	cmd_t                    cmd;
	logic                    emit;
	logic [PIX_IDX_W-1:0]    pix_idx;
	logic [2:0]              row;
	logic [2:0]              col;
	logic [10:0]             x_off;
	logic [10:0]             y_off;
	logic [GLYPH_BITS-1:0]   rest;
	logic signed [SUM_W-1:0] x_sum;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [SUM_W-1:0] x_sat;
	logic signed [SUM_W-1:0] y_sat;

	assign cmd  = pop_data[CMD_W-1:0];
	assign pop  = !busy_q && !empty;
	assign busy = busy_q;
	assign emit = busy_q && (!out_valid_q || rect_out.ready);

	// lowest lit pixel, with its row and column
	always_comb begin
		pix_idx = '0;
		row     = '0;
		col     = '0;
		for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
			for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
				if (mask_q[r*GLYPH_COLS + c]) begin
					pix_idx = PIX_IDX_W'(r*GLYPH_COLS + c);
					row     = 3'(r);
					col     = 3'(c);
				end
			end
		end
	end

	assign rest  = mask_q & ~(GLYPH_BITS'(1) << pix_idx);
	assign x_off = 11'(col) * 11'(scale_q);
	assign y_off = 11'(row) * 11'(scale_q);

	assign x_sum = SUM_W'(cursor_q) + SUM_W'(x_off) + SUM_W'(shadow_q);
	assign y_sum = SUM_W'(base_y_q) + SUM_W'(y_off) + SUM_W'(shadow_q);
	assign x_sat = sat_coord(x_sum, CW);
	assign y_sat = sat_coord(y_sum, CW);

	always_ff @(posedge clk) begin
		if (pop) begin
			cursor_q <= pop_data[CW+CMD_W-1:CMD_W];
			base_y_q <= cmd.base_y;
			scale_q  <= cmd.scale;
			color_q  <= cmd.color;
			shadow_q <= cmd.shadow;
		end
		if (emit) begin
			rect_x_q     <= x_sat[15:0];
			rect_y_q     <= y_sat[15:0];
			rect_size_q  <= scale_q;
			rect_color_q <= color_q;
			last_q       <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				mask_q <= cmd.glyph;
			end else if (emit) begin
				busy_q <= (rest != '0);
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rect_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rect_out.valid         = out_valid_q;
	assign rect_out.rect_x        = rect_x_q;
	assign rect_out.rect_y        = rect_y_q;
	assign rect_out.rect_size     = rect_size_q;
	assign rect_out.rect_color    = rect_color_q;
	assign rect_out.last_of_glyph = last_q;

endmodule

@@ dv/bitmap_font_glyph_rasterizer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_glyph_rasterizer_core_test
// Drives character items into the 5x7 glyph rasterizer and predicts every
// square it should emit from a local font walker with its own cursor and
// register copies. A directed table covers the code boundaries, both passes,
// blank and non-printable codes, zero scale and coordinate saturation. It is
// followed by random strings under random register settings, with idle bursts
// on both channels and a long output hold-off. Each square is compared field
// by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_rasterizer_core_test;
	import bfg_pkg::*;

	localparam int COORD_W        = 16;
	localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN      = -COORD_MAX - 1;
	localparam int DRAIN_CYCLES   = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 31;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         size;
		logic [31:0]        color;
		logic               last;
	} square_t;

	typedef enum logic [1:0] {BY_MODEL, NO_SQUARE, ONE_SQUARE} check_kind_e;
	typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
		logic [7:0]  code;
		logic        pass;
		logic        start;
		check_kind_e check;
		square_t     sq;
	} plan_row_t;

	localparam plan_row_t GLYPH_PLAN [34] = '{
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b1, 1'b0, ONE_SQUARE,
			'{16'sh0002, 16'sh0004, 8'h01, 32'hFFFF_FFFF, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h00, 1'b0, 1'b0, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h20, 1'b1, 1'b0, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b0, 1'b0, ONE_SQUARE,
			'{16'sh0015, 16'sh0005, 8'h01, 32'h0000_00BF, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'hFF, 1'b1, 1'b1, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h7F, 1'b0, 1'b0, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h1F, 1'b1, 1'b0, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h7E, 1'b1, 1'b1, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h21, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h23, 1'b1, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h42, 1'b0, 1'b1, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_X, 32'h0000_7FFF, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_Y, 32'h0000_7FFF, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_PIXEL_SCALE, 32'h0000_00FF, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_TEXT_COLOR, 32'h1234_5678, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b1, 1'b1, ONE_SQUARE,
			'{16'sh7FFF, 16'sh7FFF, 8'hFF, 32'h1234_5678, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b0, 1'b0, ONE_SQUARE,
			'{16'sh7FFF, 16'sh7FFF, 8'hFF, 32'h0000_005A, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h4D, 1'b1, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_X, 32'h0000_8000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_Y, 32'h0000_8000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_PIXEL_SCALE, 32'h0000_0000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_TEXT_COLOR, 32'h0000_0000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b1, 1'b1, ONE_SQUARE,
			'{16'sh8002, 16'sh8004, 8'h01, 32'h0000_0000, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h2E, 1'b0, 1'b0, ONE_SQUARE,
			'{16'sh8009, 16'sh8005, 8'h01, 32'h0000_0000, 1'b1}},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h57, 1'b1, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h80, 1'b0, 1'b0, NO_SQUARE, '0},
		'{ROW_REG, CFG_TEXT_COLOR, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_PIXEL_SCALE, 32'h0000_0001, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_X, 32'h0000_0000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_REG, CFG_ORIGIN_Y, 32'h0000_0000, 8'h00, 1'b0, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h67, 1'b0, 1'b1, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h7C, 1'b1, 1'b0, BY_MODEL, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h0A, 1'b1, 1'b0, NO_SQUARE, '0},
		'{ROW_CHAR, CFG_ORIGIN_X, 32'h0, 8'h40, 1'b1, 1'b0, BY_MODEL, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	bfg_in_if  glyph_ch ();
	bfg_out_if rect_ch ();

	bitmap_font_glyph_rasterizer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.glyph_in (glyph_ch),
		.rect_out (rect_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic signed [15:0] cursor_q   = '0;
	logic signed [15:0] origin_x_q = '0;
	logic signed [15:0] origin_y_q = '0;
	logic [7:0]         scale_q    = 8'd1;
	logic [31:0]        color_q    = 32'hFFFF_FFFF;

	square_t   glyph_squares [$];
	square_t   pending_squares [$];
	square_t   want;
	plan_row_t row;
	int        mismatches  = 0;
	int        idle_cycles = 0;
	bit        idling      = 1'b1;
	bit        stall_sink  = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int clamp_coord(input int v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end else if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	// walks the glyph bitmap and advances the cursor
	function automatic void rasterize(input logic [7:0] ch, input logic pass, input logic start);
		int          sc;
		int          off;
		int          alpha;
		logic [31:0] col;
		logic [4:0]  bits;
		square_t     sq;
		glyph_squares.delete();
		sc = (scale_q == 8'd0) ? 1 : int'(scale_q);
		off = pass ? 0 : 1;
		alpha = int'(color_q[7:0]);
		col = pass ? color_q : 32'((alpha * 3) >> 2);
		if (start) begin
			cursor_q = origin_x_q;
		end
		if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
			for (int r = 0; r < GLYPH_ROWS; r++) begin
				bits = FONT_ROM[ch - CHAR_FIRST][r];
				for (int c = 0; c < GLYPH_COLS; c++) begin
					if (bits[GLYPH_COLS - 1 - c]) begin
						sq.x = 16'(clamp_coord(int'(cursor_q) + c * sc + off));
						sq.y = 16'(clamp_coord(int'(origin_y_q) + r * sc + off));
						sq.size = 8'(sc);
						sq.color = col;
						sq.last = 1'b0;
						glyph_squares = {glyph_squares, sq};
					end
				end
			end
			if (glyph_squares.size() != 0) begin
				glyph_squares[glyph_squares.size() - 1].last = 1'b1;
			end
		end
		cursor_q = 16'(clamp_coord(int'(cursor_q) + CELL_ADVANCE * sc));
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF - 16'($urandom_range(0, 300));
			1: return 16'h8000 + 16'($urandom_range(0, 300));
			2: return 16'($urandom_range(0, 200));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_glyph(input logic [7:0] ch, input logic pass, input logic start,
		input check_kind_e check, input square_t typed);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			glyph_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		glyph_ch.valid <= 1'b1;
		glyph_ch.char_code <= ch;
		glyph_ch.mode <= pass;
		glyph_ch.first_of_string <= start;
		do @(posedge clk); while (!glyph_ch.ready);
		rasterize(ch, pass, start);
		case (check)
			BY_MODEL: pending_squares = {pending_squares, glyph_squares};
			ONE_SQUARE: pending_squares = {pending_squares, typed};
			default: ;
		endcase
	endtask

	// registers change only once every square is out and blank codes have retired
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		glyph_ch.valid <= 1'b0;
		while (pending_squares.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ORIGIN_X: origin_x_q = val[15:0];
			CFG_ORIGIN_Y: origin_y_q = val[15:0];
			CFG_PIXEL_SCALE: scale_q = val[7:0];
			CFG_TEXT_COLOR: color_q = val;
			default: ;
		endcase
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t ns: %s expected %h, got %h", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rect_ch.valid && rect_ch.ready) begin
			if (pending_squares.size() == 0) begin
				mismatches++;
				$display("%0t ns: square x %h y %h expected none, got one", $time,
					rect_ch.rect_x, rect_ch.rect_y);
			end else begin
				want = pending_squares.pop_front();
				check_field("rect_x", {16'h0, want.x}, {16'h0, rect_ch.rect_x});
				check_field("rect_y", {16'h0, want.y}, {16'h0, rect_ch.rect_y});
				check_field("rect_size", {24'h0, want.size}, {24'h0, rect_ch.rect_size});
				check_field("rect_color", want.color, rect_ch.rect_color);
				check_field("last_of_glyph", {31'h0, want.last}, {31'h0, rect_ch.last_of_glyph});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (glyph_ch.valid && glyph_ch.ready) || (rect_ch.valid && rect_ch.ready))
		begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// output side: random back-pressure and one long hold-off
	initial begin
		int n;
		forever begin
			if (stall_sink) begin
				rect_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_sink = 1'b0;
			end else if (idling && $urandom_range(0, 4) == 0) begin
				rect_ch.ready <= 1'b0;
				n = $urandom_range(1, 17);
				repeat (n) @(posedge clk);
			end else begin
				rect_ch.ready <= 1'b1;
				n = $urandom_range(1, 12);
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin
		int         sent;
		int         len;
		int         passes;
		int         sc;
		logic       pass;
		logic [7:0] text [12];
		logic [31:0] col;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		glyph_ch.valid <= 1'b0;
		glyph_ch.char_code <= '0;
		glyph_ch.mode <= 1'b0;
		glyph_ch.first_of_string <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(GLYPH_PLAN); i++) begin
			row = GLYPH_PLAN[i];
			if (row.kind == ROW_REG) begin
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_glyph(row.code, row.pass, row.start, row.check, row.sq);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			write_reg(CFG_ORIGIN_X, {16'h0, pick_coord()});
			write_reg(CFG_ORIGIN_Y, {16'h0, pick_coord()});
			case ($urandom_range(0, 9))
				0: sc = 0;
				1: sc = 255;
				2: sc = $urandom_range(1, 255);
				default: sc = $urandom_range(1, 4);
			endcase
			write_reg(CFG_PIXEL_SCALE, 32'(sc));
			case ($urandom_range(0, 7))
				0: col = 32'h0000_0000;
				1: col = 32'hFFFF_FFFF;
				default: col = $urandom;
			endcase
			write_reg(CFG_TEXT_COLOR, col);
			idling = (phase % 3 != 2) && (phase != PHASES - 1);
			if (phase == 2) begin
				stall_sink = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 12);
				if ($urandom_range(0, 7) == 0) begin
					// noise: any code, any pass, stray string starts
					for (int k = 0; k < len; k++) begin
						send_glyph(8'($urandom), 1'($urandom), 1'($urandom), BY_MODEL, '0);
					end
					sent += len;
				end else begin
					for (int k = 0; k < len; k++) begin
						text[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
							8'($urandom_range(CHAR_FIRST, CHAR_LAST));
					end
					// shadow pass then main pass of the same string, or a single pass
					passes = $urandom_range(1, 2);
					for (int p = 0; p < passes; p++) begin
						pass = (passes == 2) ? 1'(p) : 1'($urandom);
						for (int k = 0; k < len; k++) begin
							send_glyph(text[k], pass, k == 0, BY_MODEL, '0);
						end
						sent += len;
					end
				end
			end
		end

		glyph_ch.valid <= 1'b0;
		while (pending_squares.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bfg_pkg.sv
rtl/bfg_if.sv
rtl/bfg_front.sv
rtl/bfg_fifo.sv
rtl/bfg_back.sv
rtl/bitmap_font_glyph_rasterizer_core.sv
dv/bitmap_font_glyph_rasterizer_core_test.sv
